FILE: design/plta_pkg.sv
// Package for the path length and turning angle block.
// Constants, widths and the CORDIC arctangent table; no dependencies.
package plta_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int CORDIC_STEPS = 20;
    localparam int YAW_WIDTH    = 19;
    localparam int LEN_WIDTH    = 48;
    localparam int TURN_WIDTH   = 40;
    localparam int STEP_WIDTH   = COORD_WIDTH + 1;
    // CORDIC working width: operands are normalized to 2^47..2^48, plus growth
    localparam int CW           = 52;
    localparam int ZW           = 36;
    // dx^2 + dy^2 and square root working width
    localparam int SQ_BITS      = 2 * STEP_WIDTH + 2;
    localparam int NORM_TOP     = 47;

    localparam logic [LEN_WIDTH-1:0]  LEN_MAX  = '1;
    localparam logic [TURN_WIDTH-1:0] TURN_MAX = '1;
    localparam logic signed [ZW-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [ZW-1:0] ANG_TWO_PI  = 36'sd6746518852;

    localparam logic [1:0] REG_START_YAW = 2'd0;
    localparam logic [1:0] REG_GOAL_YAW  = 2'd1;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] t;
        unique case (i)
            5'd0:  t = 32'h3243F6A8;
            5'd1:  t = 32'h1DAC6705;
            5'd2:  t = 32'h0FADBAFC;
            5'd3:  t = 32'h07F56EA6;
            5'd4:  t = 32'h03FEAB76;
            5'd5:  t = 32'h01FFD55B;
            5'd6:  t = 32'h00FFFAAA;
            5'd7:  t = 32'h007FFF55;
            5'd8:  t = 32'h003FFFEA;
            5'd9:  t = 32'h001FFFFD;
            5'd10: t = 32'h000FFFFF;
            5'd11: t = 32'h0007FFFF;
            5'd12: t = 32'h0003FFFF;
            5'd13: t = 32'h0001FFFF;
            5'd14: t = 32'h0000FFFF;
            5'd15: t = 32'h00007FFF;
            5'd16: t = 32'h00003FFF;
            5'd17: t = 32'h00001FFF;
            5'd18: t = 32'h00000FFF;
            5'd19: t = 32'h000007FF;
            5'd20: t = 32'h000003FF;
            5'd21: t = 32'h000001FF;
            5'd22: t = 32'h000000FF;
            5'd23: t = 32'h0000007F;
            5'd24: t = 32'h0000003F;
            5'd25: t = 32'h0000001F;
            5'd26: t = 32'h0000000F;
            5'd27: t = 32'h00000008;
            5'd28: t = 32'h00000004;
            5'd29: t = 32'h00000002;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

FILE: design/path_length_and_turning_angle.sv
// Top level of the path length and turning angle block.
// Depends on plta_pkg (widths, constants, arctangent table).
//
// Usage:
//  - Path points enter on the s_ channel, one item per point. s_tdata holds
//    point_x in [31:0] and point_y in [63:32]; s_tlast marks the last point.
//  - On a last point one result item leaves on the m_ channel: m_tdata holds
//    total_length [47:0], total_turning [87:48]; m_tuser[0] is overflowed.
//  - start_yaw (index 0) and goal_yaw (index 1) are to be written on the cfg
//    port only while the block is idle; the block does not enforce this.
//    They survive the end of a path.
//  - Each point after the first takes a sequence on one shared datapath: a
//    squared-length step (two multiplies) and a 34-step shift-and-subtract
//    square root; from the third point on, two CORDIC vectoring passes
//    (normalize shifts plus 20 iterations each) give the segment angles.
//  - On a last point the result is registered in ST_FINISH and m_tvalid rises
//    in ST_OUT.
//  - s_tready is low while an item is in work and while a result waits in
//    the output register; a stalled receiver holds the block, losing nothing.
//  - aresetn (synchronous, active low) clears the path state, the yaw
//    registers and any pending result.
module path_length_and_turning_angle
    import plta_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // point_x [31:0], point_y [63:32]
    input  logic                  s_tlast,   // last_point
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [87:0]           m_tdata,   // total_length [47:0], total_turning [87:48]
    output logic                  m_tuser,   // overflowed
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [YAW_WIDTH-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQUARE, ST_SQRT, ST_LEN_ADD, ST_ANG_LOAD, ST_NORM,
        ST_QUAD, ST_ITER, ST_ANG_DONE, ST_TURN, ST_FINISH, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic signed [YAW_WIDTH-1:0]   start_yaw_reg, goal_yaw_reg;
    logic signed [COORD_WIDTH-1:0] prior_x_reg, prior_y_reg;
    logic signed [STEP_WIDTH-1:0]  prior_step_x_reg, prior_step_y_reg;
    logic signed [STEP_WIDTH-1:0]  dx_reg, dy_reg;
    logic [1:0]                    points_seen_reg;
    logic [LEN_WIDTH-1:0]          length_sum_reg;
    logic [TURN_WIDTH-1:0]         turning_sum_reg;
    logic                          sum_saturated_reg;
    logic                          last_reg;
    logic                          has_turn_reg;  // this point adds a turning angle
    logic                          second_reg;    // CORDIC pass on the new segment
    logic [SQ_BITS-1:0]            norm_sq_reg;   // dx^2 + dy^2, then remainder
    logic [SQ_BITS-1:0]            root_reg;
    logic [SQ_BITS-1:0]            one_reg;       // current power of four
    logic [5:0]                    bit_reg;
    logic signed [CW-1:0]          cx_reg, cy_reg;
    logic signed [ZW-1:0]          cz_reg, ang1_reg;
    logic [4:0]                    iter_reg;
    logic [LEN_WIDTH-1:0]          out_len_reg;
    logic [TURN_WIDTH-1:0]         out_turn_reg;
    logic                          out_ovf_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {out_turn_reg, out_len_reg};
    assign m_tuser  = out_ovf_reg;

    // ---- combinational helpers for the shared unit ----
    logic signed [STEP_WIDTH:0] new_dx, new_dy;
    logic [STEP_WIDTH-1:0]      adx, ady;
    logic [SQ_BITS-1:0]         sq_trial;
    logic [CW-1:0]              ax, ay, amax;
    logic signed [CW-1:0]       sx, sy;
    logic signed [ZW-1:0]       atan_v, ang_d, ang_w, ang_a;
    logic [TURN_WIDTH:0]        turn_add;
    logic [TURN_WIDTH:0]        turn_sum_w;
    logic [LEN_WIDTH:0]         len_sum_w;
    logic signed [YAW_WIDTH:0]  yaw_diff;
    logic [YAW_WIDTH:0]         yaw_abs;
    logic [TURN_WIDTH-1:0]      yaw_add;
    logic                       zero_seg;

    assign new_dx = $signed(s_tdata[31:0])  - prior_x_reg;
    assign new_dy = $signed(s_tdata[63:32]) - prior_y_reg;
    assign adx = dx_reg[STEP_WIDTH-1] ? STEP_WIDTH'(-dx_reg) : dx_reg;
    assign ady = dy_reg[STEP_WIDTH-1] ? STEP_WIDTH'(-dy_reg) : dy_reg;
    assign sq_trial = root_reg + one_reg;
    assign ax = cx_reg[CW-1] ? CW'(-cx_reg) : cx_reg;
    assign ay = cy_reg[CW-1] ? CW'(-cy_reg) : cy_reg;
    assign amax = (ax > ay) ? ax : ay;
    assign sx = cx_reg >>> iter_reg;
    assign sy = cy_reg >>> iter_reg;
    assign atan_v = ZW'(atan_entry(iter_reg));
    assign ang_d = cz_reg - ang1_reg;
    always_comb begin
        ang_w = ang_d;
        if (ang_d > ANG_PI) ang_w = ang_d - ANG_TWO_PI;
        else if (ang_d < -ANG_PI) ang_w = ang_d + ANG_TWO_PI;
        ang_a = ang_w[ZW-1] ? -ang_w : ang_w;
        if (ang_a > ANG_PI) ang_a = ANG_PI;
    end
    assign zero_seg = (prior_step_x_reg == '0 && prior_step_y_reg == '0) ||
                      (dx_reg == '0 && dy_reg == '0);
    assign turn_add = zero_seg ? '0 : (TURN_WIDTH+1)'((ang_a + ZW'(8192)) >>> 14);
    assign turn_sum_w = {1'b0, turning_sum_reg} + turn_add;
    assign len_sum_w  = {1'b0, length_sum_reg} + (LEN_WIDTH+1)'(root_reg);
    assign yaw_diff = start_yaw_reg - goal_yaw_reg;
    assign yaw_abs  = yaw_diff[YAW_WIDTH] ? (YAW_WIDTH+1)'(-yaw_diff) : yaw_diff;
    assign yaw_add  = TURN_WIDTH'(yaw_abs);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = (points_seen_reg == 2'd0) ?
                             (s_tlast ? ST_FINISH : ST_IDLE) : ST_SQUARE;
            ST_SQUARE:   state_next = ST_SQRT;
            ST_SQRT:     if (bit_reg == 6'd0) state_next = ST_LEN_ADD;
            ST_LEN_ADD:  state_next = has_turn_reg ? ST_ANG_LOAD :
                             (last_reg ? ST_FINISH : ST_IDLE);
            ST_ANG_LOAD: state_next = ST_NORM;
            ST_NORM:     if (amax == '0 || amax[NORM_TOP]) state_next = ST_QUAD;
            ST_QUAD:     state_next = ST_ITER;
            ST_ITER:     if (iter_reg == 5'(CORDIC_STEPS - 1)) state_next = ST_ANG_DONE;
            ST_ANG_DONE: state_next = second_reg ? ST_TURN : ST_ANG_LOAD;
            ST_TURN:     state_next = last_reg ? ST_FINISH : ST_IDLE;
            ST_FINISH:   state_next = ST_OUT;
            ST_OUT:      if (m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            start_yaw_reg     <= '0;
            goal_yaw_reg      <= '0;
            prior_x_reg       <= '0;
            prior_y_reg       <= '0;
            prior_step_x_reg  <= '0;
            prior_step_y_reg  <= '0;
            points_seen_reg   <= '0;
            length_sum_reg    <= '0;
            turning_sum_reg   <= '0;
            sum_saturated_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == REG_START_YAW) start_yaw_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_GOAL_YAW)  goal_yaw_reg  <= cfg_data;
            unique case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    last_reg     <= s_tlast;
                    has_turn_reg <= (points_seen_reg == 2'd2);
                    dx_reg       <= STEP_WIDTH'(new_dx);
                    dy_reg       <= STEP_WIDTH'(new_dy);
                    prior_x_reg  <= $signed(s_tdata[31:0]);
                    prior_y_reg  <= $signed(s_tdata[63:32]);
                    if (points_seen_reg != 2'd2) points_seen_reg <= points_seen_reg + 2'd1;
                end
                ST_SQUARE: begin
                    norm_sq_reg <= SQ_BITS'(adx * adx) + SQ_BITS'(ady * ady);
                    root_reg    <= '0;
                    one_reg     <= SQ_BITS'(1) << (SQ_BITS - 2);
                    bit_reg     <= 6'(SQ_BITS / 2 - 1);
                end
                // one root bit per cycle: compare and subtract against root + 4^k
                ST_SQRT: begin
                    if (norm_sq_reg >= sq_trial) begin
                        norm_sq_reg <= norm_sq_reg - sq_trial;
                        root_reg    <= (root_reg >> 1) + one_reg;
                    end else begin
                        root_reg    <= root_reg >> 1;
                    end
                    one_reg <= one_reg >> 2;
                    bit_reg <= bit_reg - 6'd1;
                end
                ST_LEN_ADD: begin
                    if (len_sum_w[LEN_WIDTH]) begin
                        length_sum_reg    <= LEN_MAX;
                        sum_saturated_reg <= 1'b1;
                    end else begin
                        length_sum_reg <= len_sum_w[LEN_WIDTH-1:0];
                    end
                    second_reg <= 1'b0;
                    if (!has_turn_reg) begin
                        prior_step_x_reg <= dx_reg;
                        prior_step_y_reg <= dy_reg;
                    end
                end
                ST_ANG_LOAD: begin
                    cx_reg <= second_reg ? CW'(dx_reg) : CW'(prior_step_x_reg);
                    cy_reg <= second_reg ? CW'(dy_reg) : CW'(prior_step_y_reg);
                    cz_reg <= '0;
                end
                ST_NORM: if (!(amax == '0 || amax[NORM_TOP])) begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
                ST_QUAD: begin
                    iter_reg <= '0;
                    if (cx_reg[CW-1]) begin
                        if (!cy_reg[CW-1]) begin
                            cx_reg <= cy_reg; cy_reg <= -cx_reg; cz_reg <= ANG_HALF_PI;
                        end else begin
                            cx_reg <= -cy_reg; cy_reg <= cx_reg; cz_reg <= -ANG_HALF_PI;
                        end
                    end
                end
                ST_ITER: begin
                    if (!cy_reg[CW-1] && cy_reg != '0) begin
                        cx_reg <= cx_reg + sy; cy_reg <= cy_reg - sx; cz_reg <= cz_reg + atan_v;
                    end else begin
                        cx_reg <= cx_reg - sy; cy_reg <= cy_reg + sx; cz_reg <= cz_reg - atan_v;
                    end
                    iter_reg <= iter_reg + 5'd1;
                end
                ST_ANG_DONE: begin
                    if (!second_reg) ang1_reg <= cz_reg;
                    second_reg <= 1'b1;
                end
                ST_TURN: begin
                    if (turn_sum_w[TURN_WIDTH]) begin
                        turning_sum_reg   <= TURN_MAX;
                        sum_saturated_reg <= 1'b1;
                    end else begin
                        turning_sum_reg <= turn_sum_w[TURN_WIDTH-1:0];
                    end
                    prior_step_x_reg <= dx_reg;
                    prior_step_y_reg <= dy_reg;
                end
                ST_FINISH: begin
                    out_len_reg <= length_sum_reg;
                    if ({1'b0, turning_sum_reg} + {1'b0, yaw_add} > {1'b0, TURN_MAX}) begin
                        out_turn_reg <= TURN_MAX;
                        out_ovf_reg  <= 1'b1;
                    end else begin
                        out_turn_reg <= turning_sum_reg + yaw_add;
                        out_ovf_reg  <= sum_saturated_reg;
                    end
                    prior_x_reg       <= '0;
                    prior_y_reg       <= '0;
                    prior_step_x_reg  <= '0;
                    prior_step_y_reg  <= '0;
                    points_seen_reg   <= '0;
                    length_sum_reg    <= '0;
                    turning_sum_reg   <= '0;
                    sum_saturated_reg <= 1'b0;
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_seen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        points_seen_reg != 2'd3) else $error("points_seen overrun");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> points_seen_reg == 2'd0 && length_sum_reg == '0)
        else $error("path state not cleared");

endmodule
